// ===== hw/rtl/aes_pkg.sv =====
// AES-128 shared package: S-box tables, round transforms, widths.
// No dependencies; used by the cipher core and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

   localparam int BLOCK_W    = 128;
   localparam int HALF_W     = 64;
   localparam int NUM_RKEYS  = 11;
   localparam int RKEY_AW    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;
   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // byte i of the block sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
      get_byte = s[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s,
                                                    input logic inv);
      logic [BLOCK_W-1:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv)
               t[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] = INV_BOX[get_byte(s, r+4*c)];
            else
               t[BLOCK_W-1-8*(r+4*c) -: 8] = FWD_BOX[get_byte(s, r+4*((c+r)%4))];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] s, input logic inv);
      logic [BLOCK_W-1:0] t;
      logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
      logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         if (inv) begin
            // premultiply brings inverse mix back to the forward matrix
            x0 = xt(xt(a0 ^ a2));
            x1 = xt(xt(a1 ^ a3));
            b0 = a0 ^ x0;
            b1 = a1 ^ x1;
            b2 = a2 ^ x0;
            b3 = a3 ^ x1;
         end else begin
            b0 = a0;
            b1 = a1;
            b2 = a2;
            b3 = a3;
         end
         y0 = xt(b0);
         y1 = xt(b1);
         y2 = xt(b2);
         y3 = xt(b3);
         x0 = y0 ^ y1 ^ b1 ^ b2 ^ b3;
         x1 = b0 ^ y1 ^ y2 ^ b2 ^ b3;
         x2 = b0 ^ b1 ^ y2 ^ y3 ^ b3;
         x3 = y0 ^ b0 ^ b1 ^ b2 ^ y3;
         t[BLOCK_W-1-32*c -: 32] = {x0, x1, x2, x3};
      end
      mix = t;
   endfunction

   // next round key from the previous one
   function automatic logic [BLOCK_W-1:0] next_rkey(input logic [BLOCK_W-1:0] k,
                                                    input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      tw = {FWD_BOX[w3[23:16]], FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
      tw = tw ^ {rc, 24'h0};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_rkey = {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes128_block_cipher.sv =====
// Round-iterative AES-128: one round a cycle out of a round key RAM.
// An accepted beat passes through RUN and DONE before result valid; one block in flight.
// A new block is taken only after the last one has had its 11 key additions and left DONE.
// Key expansion after reset or any key write holds req_stall high.
// Reset (synchronous, active high) clears the key to zero and re-expands.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [63:0] rsp_result_high,
   output logic      [63:0] rsp_result_low
);
   localparam logic [1:0] ST_EXPAND = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam int BW = aes_pkg::BLOCK_W;
   localparam int AW = aes_pkg::RKEY_AW;
   localparam logic [AW-1:0] LAST = AW'(aes_pkg::NUM_RKEYS - 1);

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [63:0]   key_hi_ff, key_lo_ff;
   logic [BW-1:0] ekey_ff, ekey_in;
   logic [7:0]    rc_ff, rc_in;
   logic [BW-1:0] st_ff, st_in;
   logic          kind_ff, kind_in;
   logic          first_ff, first_in;
   logic          out_v_ff, out_v_in;
   logic [BW-1:0] out_ff;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [BW-1:0] rkey;
   logic [BW-1:0] rnd_in, sb, rnd_out;
   logic          accept, finish;

   aes_ram #(.WIDTH(BW), .DEPTH(aes_pkg::NUM_RKEYS), .AW(AW)) u_rkeys (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(cnt_ff),
      .wr_data(ekey_ff),
      .rd_addr(rd_addr),
      .rd_data(rkey)
   );

   // a key write restarts expansion, so no beat is taken in that cycle
   assign req_stall = (state_ff != ST_IDLE) || csr_write;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = (state_ff == ST_EXPAND);
   assign rsp_valid = out_v_ff;
   assign rsp_result_high = out_ff[127:64];
   assign rsp_result_low  = out_ff[63:0];

   // state holds the input block until the first key read returns
   assign rnd_in = st_ff ^ rkey;
   assign sb = aes_pkg::sub_shift(st_ff, kind_ff);
   always_comb begin
      if (kind_ff == aes_pkg::KIND_ENCRYPT)
         rnd_out = (cnt_ff == LAST) ? (sb ^ rkey) : (aes_pkg::mix(sb, 1'b0) ^ rkey);
      else
         rnd_out = (cnt_ff == LAST) ? (sb ^ rkey) : aes_pkg::mix(sb ^ rkey, 1'b1);
   end

   always_comb begin
      rd_addr = cnt_ff;
      if (state_ff == ST_IDLE)
         rd_addr = req_kind ? LAST : '0;
      else if (state_ff == ST_RUN) begin
         // fetch key for next step; encrypt counts up, decrypt down
         if (first_ff)
            rd_addr = kind_ff ? (LAST - AW'(1)) : AW'(1);
         else if (cnt_ff != LAST)
            rd_addr = kind_ff ? (LAST - cnt_ff - AW'(1)) : (cnt_ff + AW'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ekey_in  = ekey_ff;
      rc_in    = rc_ff;
      st_in    = st_ff;
      kind_in  = kind_ff;
      first_in = first_ff;
      out_v_in = out_v_ff && rsp_stall;
      finish   = 1'b0;
      unique case (state_ff)
         ST_EXPAND: begin
            ekey_in = aes_pkg::next_rkey(ekey_ff, rc_ff);
            rc_in   = aes_pkg::xt(rc_ff);
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == LAST) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               st_in    = {req_block_high, req_block_low};
               kind_in  = req_kind;
               first_in = 1'b1;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (first_ff) begin
               st_in    = rnd_in;
               first_in = 1'b0;
               cnt_in   = AW'(1);
            end else begin
               st_in  = rnd_out;
               cnt_in = cnt_ff + AW'(1);
               if (cnt_ff == LAST) begin
                  cnt_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!out_v_ff || !rsp_stall) begin
               finish   = 1'b1;
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counts rounds 1..10 in RUN; in decrypt the key index is LAST - cnt
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_EXPAND;
         cnt_ff    <= '0;
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         ekey_ff   <= '0;
         rc_ff     <= 8'h01;
         out_v_ff  <= 1'b0;
         first_ff  <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == aes_pkg::CSR_KEY_HIGH) begin
            key_hi_ff <= csr_data;
         end else if (csr_index == aes_pkg::CSR_KEY_LOW) begin
            key_lo_ff <= csr_data;
         end
         state_ff <= ST_EXPAND;
         cnt_ff   <= '0;
         rc_ff    <= 8'h01;
         ekey_ff  <= (csr_index == aes_pkg::CSR_KEY_HIGH) ? {csr_data, key_lo_ff}
                                                          : {key_hi_ff, csr_data};
         out_v_ff <= out_v_in;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ekey_ff  <= ekey_in;
         rc_ff    <= rc_in;
         out_v_ff <= out_v_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      kind_ff <= kind_in;
      if (finish)
         out_ff <= st_ff;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/aes_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module aes_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
// Port-level checker for the AES-128 core, bound to the top level.
// Depends on aes128_block_cipher ports only.
`timescale 1ns / 1ps
`default_nettype none
module aes_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_result_high,
   input wire logic [63:0] rsp_result_low
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted beat did not close input");
   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_high)
      && $stable(rsp_result_low))
      else $error("stalled result changed");
   // first cycle out of reset is spent expanding the key
   a_reset_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input open during key expansion");
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_high(rsp_result_high), .rsp_result_low(rsp_result_low)
);
`default_nettype wire

// ===== tb/tb_aes128_block_cipher.sv =====
// Testbench for the AES-128 ECB block cipher: directed vectors, then random blocks.
// Depends on aes_pkg (S-box tables, register and direction codes) and aes128_block_cipher.
`timescale 1ns / 1ps
`default_nettype none
module tb_aes128_block_cipher;

   typedef struct {
      logic        kind;
      logic [63:0] blk_hi;
      logic [63:0] blk_lo;
      logic        known;   // expected result typed in below
      logic [63:0] want_hi;
      logic [63:0] want_lo;
   } vec_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   localparam int N_RANDOM  = 1000;
   localparam int CYC_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = aes_pkg::CSR_KEY_HIGH;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_kind = aes_pkg::KIND_ENCRYPT;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_stall = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [63:0] rsp_result_high;
   wire  [63:0] rsp_result_low;

   aes128_block_cipher DUT (.*);

   always #5 clock = ~clock;

   // model state: key and expanded schedule
   logic [127:0] cipher_key;
   logic [127:0] sched [11];
   block_type    pending_blocks [$];
   int           n_errors = 0;
   int           n_checked = 0;
   int           n_enc = 0, n_dec = 0;
   int           n_keys = 0;
   longint       cycles = 0;
   bit           calm = 1'b0;   // no idling on either side

   function automatic logic [7:0] sbox_byte(logic [7:0] a, bit inv);
      return inv ? aes_pkg::INV_BOX[a] : aes_pkg::FWD_BOX[a];
   endfunction

   function automatic logic [7:0] gf_dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] m);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (m[i]) r ^= a;
         a = gf_dbl(a);
      end
      return r;
   endfunction

   function automatic void expand_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = cipher_key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_byte(t[31:24], 1'b0), sbox_byte(t[23:16], 1'b0),
                 sbox_byte(t[15:8], 1'b0), sbox_byte(t[7:0], 1'b0)} ^ {rc, 24'h0};
            rc = gf_dbl(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   // state byte n lives at bits [127-8n -: 8]
   function automatic logic [127:0] subst_rows(logic [127:0] s, bit inv);
      logic [127:0] t;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            if (inv)
               t[127-8*(r+4*((c+r)%4)) -: 8] = sbox_byte(s[127-8*(r+4*c) -: 8], 1'b1);
            else
               t[127-8*(r+4*c) -: 8] = sbox_byte(s[127-8*(r+4*((c+r)%4)) -: 8], 1'b0);
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
      logic [127:0] t;
      logic [7:0]   coef [4];
      logic [7:0]   acc;
      if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++)
               acc ^= gf_mul(s[127-8*(4*c+j) -: 8], coef[(j-r+4)%4]);
            t[127-8*(4*c+r) -: 8] = acc;
         end
      return t;
   endfunction

   function automatic block_type aes_transform(logic kind, logic [63:0] hi, logic [63:0] lo);
      logic [127:0] s;
      block_type    o;
      s = {hi, lo};
      if (kind == aes_pkg::KIND_ENCRYPT) begin
         s ^= sched[0];
         for (int r = 1; r < 10; r++)
            s = mix_cols(subst_rows(s, 1'b0), 1'b0) ^ sched[r];
         s = subst_rows(s, 1'b0) ^ sched[10];
      end else begin
         s ^= sched[10];
         for (int r = 9; r >= 1; r--)
            s = mix_cols(subst_rows(s, 1'b1) ^ sched[r], 1'b1);
         s = subst_rows(s, 1'b1) ^ sched[0];
      end
      o.hi = s[127:64];
      o.lo = s[63:0];
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_blocks.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stall, compare each accepted beat
   always @(posedge clock) begin
      block_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected result beat %h_%h", rsp_result_high, rsp_result_low);
            n_errors++;
         end else begin
            e = pending_blocks.pop_front();
            n_checked++;
            if (rsp_result_high !== e.hi) begin
               $error("result_high expected %h actual %h", e.hi, rsp_result_high);
               n_errors++;
            end
            if (rsp_result_low !== e.lo) begin
               $error("result_low expected %h actual %h", e.lo, rsp_result_low);
               n_errors++;
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 16);
   end

   task automatic write_key(logic [0:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == aes_pkg::CSR_KEY_HIGH) cipher_key[127:64] = val;
      else                              cipher_key[63:0]   = val;
      expand_schedule();
      n_keys++;
   endtask

   task automatic wait_idle();
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // drive one block; valid stays up across back-to-back beats
   task automatic send_block(logic kind, logic [63:0] hi, logic [63:0] lo);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_block_high <= hi;
      req_block_low  <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_blocks.push_back(aes_transform(kind, hi, lo));
      if (kind == aes_pkg::KIND_ENCRYPT) n_enc++; else n_dec++;
      if (!calm) while ($urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic set_key(logic [127:0] k);
      wait_idle();
      write_key(aes_pkg::CSR_KEY_HIGH, k[127:64]);
      write_key(aes_pkg::CSR_KEY_LOW, k[63:0]);
   endtask

   vec_type directed [] = '{
      // zero key: known zero-block encryption
      '{aes_pkg::KIND_ENCRYPT, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{aes_pkg::KIND_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
      '{aes_pkg::KIND_ENCRYPT, '1, '1, 1'b0, 0, 0},
      '{aes_pkg::KIND_DECRYPT, '1, '1, 1'b0, 0, 0},
      '{aes_pkg::KIND_DECRYPT, 64'h0, 64'h0, 1'b0, 0, 0},
      '{aes_pkg::KIND_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, 0, 0}
   };

   // all-ones blocks, run again under the all-ones key
   vec_type ones_rows [] = '{
      '{aes_pkg::KIND_ENCRYPT, '1, '1, 1'b0, 0, 0},
      '{aes_pkg::KIND_DECRYPT, '1, '1, 1'b0, 0, 0}
   };

   // FIPS-197 appendix C.1 vector under key 000102..0f
   vec_type fips [] = '{
      '{aes_pkg::KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{aes_pkg::KIND_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{aes_pkg::KIND_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 0, 0}
   };

   task automatic run_table(vec_type tbl []);
      block_type e;
      foreach (tbl[i]) begin
         if (tbl[i].known) begin
            e = aes_transform(tbl[i].kind, tbl[i].blk_hi, tbl[i].blk_lo);
            if (e.hi !== tbl[i].want_hi || e.lo !== tbl[i].want_lo) begin
               $error("row %0d: table expects %h_%h, predictor %h_%h", i,
                      tbl[i].want_hi, tbl[i].want_lo, e.hi, e.lo);
               n_errors++;
            end
         end
         send_block(tbl[i].kind, tbl[i].blk_hi, tbl[i].blk_lo);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [127:0] k;
      cipher_key = '0;
      expand_schedule();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_table(directed);
      set_key(128'h000102030405060708090a0b0c0d0e0f);
      run_table(fips);
      set_key('1);
      run_table(ones_rows);
      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph == 2);
         case (ph)
            0:       k = '0;
            1:       k = {64'h8000000000000000, 64'h1};
            default: k = {$urandom, $urandom, $urandom, $urandom};
         endcase
         wait_idle();
         // a single half write in phase 5 also exercises re-expansion
         if (ph == 5) write_key(aes_pkg::CSR_KEY_LOW, k[63:0]);
         else set_key(k);
         for (int i = 0; i < N_RANDOM / 8; i++) begin
            // sender holds off until the pipe has drained
            if (i == 40) begin
               req_valid <= 1'b0;
               while (pending_blocks.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            send_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
         end
         req_valid <= 1'b0;
      end
      calm = 1'b0;
      wait_idle();
      $display("checked %0d blocks (%0d encrypt, %0d decrypt) over %0d key writes",
               n_checked, n_enc, n_dec, n_keys);
      if (n_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
